[hw/rtl/craft_pkg.sv]
// shared constants, tables, types and round function for the craft cipher block
`default_nettype none

package craft_pkg;

    localparam int unsigned WORD_W          = 64;
    localparam int unsigned NIBBLE_W        = 4;
    localparam int unsigned NUM_NIBBLES     = 16;
    localparam int unsigned NUM_ROUNDS      = 32;
    localparam int unsigned LAST_ROUND      = 31;
    localparam int unsigned ROUND_IDX_W     = 5;
    localparam int unsigned ROUND_CNT_W     = 6;
    localparam int unsigned CFG_IDX_W       = 3;
    localparam logic [ROUND_CNT_W-1:0] ROUND_CNT_RESET = 6'd7;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_ZERO    = 3'd0,
        REG_KEY_ONE     = 3'd1,
        REG_INPUT_MASK  = 3'd2,
        REG_OUTPUT_MASK = 3'd3,
        REG_ROUND_COUNT = 3'd4
    } cfg_reg_t;

    // payload carried down the chain of round cells
    typedef struct packed {
        logic [WORD_W-1:0] state;
        logic [WORD_W-1:0] plain;
    } craft_stage_t;

    localparam logic [3:0] SBOX [NUM_NIBBLES] = '{
        4'hc, 4'ha, 4'hd, 4'h3, 4'he, 4'hb, 4'hf, 4'h7,
        4'h8, 4'h9, 4'h1, 4'h5, 4'h0, 4'h2, 4'h4, 4'h6
    };

    localparam logic [3:0] PERM [NUM_NIBBLES] = '{
        4'd15, 4'd12, 4'd13, 4'd14, 4'd10, 4'd9, 4'd8, 4'd11,
        4'd6, 4'd5, 4'd4, 4'd7, 4'd1, 4'd2, 4'd3, 4'd0
    };

    localparam logic [3:0] RC_A [NUM_ROUNDS] = '{
        4'h1, 4'h8, 4'h4, 4'h2, 4'h9, 4'hc, 4'h6, 4'hb,
        4'h5, 4'ha, 4'hd, 4'he, 4'hf, 4'h7, 4'h3, 4'h1,
        4'h8, 4'h4, 4'h2, 4'h9, 4'hc, 4'h6, 4'hb, 4'h5,
        4'ha, 4'hd, 4'he, 4'hf, 4'h7, 4'h3, 4'h1, 4'h8
    };

    localparam logic [3:0] RC_B [NUM_ROUNDS] = '{
        4'h1, 4'h4, 4'h2, 4'h5, 4'h6, 4'h7, 4'h3, 4'h1,
        4'h4, 4'h2, 4'h5, 4'h6, 4'h7, 4'h3, 4'h1, 4'h4,
        4'h2, 4'h5, 4'h6, 4'h7, 4'h3, 4'h1, 4'h4, 4'h2,
        4'h5, 4'h6, 4'h7, 4'h3, 4'h1, 4'h4, 4'h2, 4'h5
    };

    // one cipher round; nibble 0 sits in the top four bits
    function automatic logic [WORD_W-1:0] craft_round(
        input logic [WORD_W-1:0] s,
        input logic [WORD_W-1:0] key,
        input logic [3:0]        rc_a,
        input logic [3:0]        rc_b,
        input logic              last
    );
        logic [3:0]        n [NUM_NIBBLES];
        logic [3:0]        t [NUM_NIBBLES];
        logic [WORD_W-1:0] w;
        for (int i = 0; i < NUM_NIBBLES; i++)
        begin
            n[i] = s[WORD_W-1-NIBBLE_W*i -: NIBBLE_W];
        end
        // mix columns
        for (int c = 0; c < 4; c++)
        begin
            n[c]   = n[c] ^ n[c+8] ^ n[c+12];
            n[c+4] = n[c+4] ^ n[c+12];
        end
        // round constants
        n[4] = n[4] ^ rc_a;
        n[5] = n[5] ^ rc_b;
        // tweakey
        for (int i = 0; i < NUM_NIBBLES; i++)
        begin
            n[i] = n[i] ^ key[WORD_W-1-NIBBLE_W*i -: NIBBLE_W];
        end
        // permutation and s-box, skipped in the last round
        if (!last)
        begin
            for (int i = 0; i < NUM_NIBBLES; i++)
            begin
                t[PERM[i]] = n[i];
            end
            for (int i = 0; i < NUM_NIBBLES; i++)
            begin
                n[i] = SBOX[t[i]];
            end
        end
        w = '0;
        for (int i = 0; i < NUM_NIBBLES; i++)
        begin
            w[WORD_W-1-NIBBLE_W*i -: NIBBLE_W] = n[i];
        end
        return w;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/craft_if.sv]
// handshake interfaces for plaintext, result and configuration channels
`default_nettype none

interface craft_pt_if;
    logic                           valid;
    logic                           ready;
    logic [craft_pkg::WORD_W-1:0]   plaintext;

    modport source (output valid, output plaintext, input ready);
    modport sink   (input valid, input plaintext, output ready);
endinterface

interface craft_ct_if;
    logic                           valid;
    logic                           ready;
    logic [craft_pkg::WORD_W-1:0]   ciphertext;
    logic                           mask_parity;

    modport source (output valid, output ciphertext, output mask_parity, input ready);
    modport sink   (input valid, input ciphertext, input mask_parity, output ready);
endinterface

interface craft_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [craft_pkg::CFG_IDX_W-1:0] index;
    logic [craft_pkg::WORD_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/craft_cipher_with_mask_parity.sv]
// top level: config registers, chain of 32 round cells and the output stage
`default_nettype none

// Encrypts one 64-bit plaintext per item with the CRAFT cipher under a zero
// tweak (key_zero on even rounds, key_one on odd) and returns the ciphertext
// with the parity of (plaintext & input_mask) ^ (ciphertext & output_mask).
// The datapath is a chain of 32 round cells, one round and one register
// each, followed by the output register, and a new item can enter every
// cycle while the output is not stalled. Cells past round_count pass the
// state through, so latency does not depend on the round count; counts
// above 32 act as 32 and zero returns the plaintext. Each cell has its
// own ready, so a stalled output fills empty cells before the input stops.
// Config writes are taken at any time on index 0..4 (others are dropped)
// and must be done only while no item is in flight.
module craft_cipher_with_mask_parity (
    input  wire logic   clk,
    input  wire logic   rst_n,
    craft_pt_if.sink    plain,
    craft_ct_if.source  cipher,
    craft_cfg_if.sink   cfg
);

    localparam int unsigned NR = craft_pkg::NUM_ROUNDS;

    logic [craft_pkg::WORD_W-1:0]       key_zero_reg;
    logic [craft_pkg::WORD_W-1:0]       key_one_reg;
    logic [craft_pkg::WORD_W-1:0]       input_mask_reg;
    logic [craft_pkg::WORD_W-1:0]       output_mask_reg;
    logic [craft_pkg::ROUND_CNT_W-1:0]  round_count_reg;

    logic                               stage_valid [NR+1];
    logic                               stage_ready [NR+1];
    craft_pkg::craft_stage_t            stage_data  [NR+1];
    logic [NR-1:0]                      round_en;

    // configuration write port, always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_zero_reg    <= '0;
            key_one_reg     <= '0;
            input_mask_reg  <= '0;
            output_mask_reg <= '0;
            round_count_reg <= craft_pkg::ROUND_CNT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (craft_pkg::cfg_reg_t'(cfg.index))
                craft_pkg::REG_KEY_ZERO:    key_zero_reg    <= cfg.data;
                craft_pkg::REG_KEY_ONE:     key_one_reg     <= cfg.data;
                craft_pkg::REG_INPUT_MASK:  input_mask_reg  <= cfg.data;
                craft_pkg::REG_OUTPUT_MASK: output_mask_reg <= cfg.data;
                craft_pkg::REG_ROUND_COUNT:
                    round_count_reg <= cfg.data[craft_pkg::ROUND_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // chain input
    assign stage_valid[0]       = plain.valid;
    assign plain.ready          = stage_ready[0];
    assign stage_data[0].state  = plain.plaintext;
    assign stage_data[0].plain  = plain.plaintext;

    // round cells
    for (genvar g = 0; g < NR; g++)
    begin : g_round
        assign round_en[g] = (round_count_reg > craft_pkg::ROUND_CNT_W'(g));

        craft_round_cell #(
            .ROUND (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[g]),
            .in_ready  (stage_ready[g]),
            .in_data   (stage_data[g]),
            .round_en  (round_en[g]),
            .round_key ((g % 2 == 1) ? key_one_reg : key_zero_reg),
            .out_valid (stage_valid[g+1]),
            .out_ready (stage_ready[g+1]),
            .out_data  (stage_data[g+1])
        );
    end

    // result stage
    craft_parity_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (stage_valid[NR]),
        .in_ready    (stage_ready[NR]),
        .in_data     (stage_data[NR]),
        .input_mask  (input_mask_reg),
        .output_mask (output_mask_reg),
        .cipher      (cipher)
    );

    // an empty result register lets the whole chain move
    assert property (@(posedge clk) disable iff (!rst_n)
        !cipher.valid |-> plain.ready)
        else $error("input not ready while result register empty");

    // an accepted item lands in the first cell
    assert property (@(posedge clk) disable iff (!rst_n)
        (plain.valid && plain.ready) |=> stage_valid[1])
        else $error("accepted item lost at first cell");

    // the last cell keeps its item while the result is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        (cipher.valid && !cipher.ready && stage_valid[NR]) |=> stage_valid[NR])
        else $error("last cell dropped an item under stall");

endmodule

`default_nettype wire

[hw/rtl/craft_round_cell.sv]
// one round cell of the cipher chain: one round of logic and one pipeline register
`default_nettype none

module craft_round_cell #(
    parameter int unsigned ROUND = 0
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire craft_pkg::craft_stage_t        in_data,
    input  wire logic                           round_en,
    input  wire logic [craft_pkg::WORD_W-1:0]   round_key,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output craft_pkg::craft_stage_t             out_data
);

    localparam logic [craft_pkg::ROUND_IDX_W-1:0] RIDX =
        craft_pkg::ROUND_IDX_W'(ROUND);
    localparam logic IS_LAST = (ROUND == craft_pkg::LAST_ROUND);

    logic                       valid_reg;
    craft_pkg::craft_stage_t    data_reg;
    craft_pkg::craft_stage_t    data_next;

    // cell takes a new item when empty or when its item moves on
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // round logic, bypassed beyond the configured round count
    always_comb
    begin
        data_next.plain = in_data.plain;
        if (round_en)
        begin
            data_next.state = craft_pkg::craft_round(in_data.state, round_key,
                                                     craft_pkg::RC_A[RIDX],
                                                     craft_pkg::RC_B[RIDX], IS_LAST);
        end
        else
        begin
            data_next.state = in_data.state;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/craft_parity_out.sv]
// output stage: masked parity and the result register
`default_nettype none

module craft_parity_out (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire craft_pkg::craft_stage_t        in_data,
    input  wire logic [craft_pkg::WORD_W-1:0]   input_mask,
    input  wire logic [craft_pkg::WORD_W-1:0]   output_mask,
    craft_ct_if.source                          cipher
);

    logic                           valid_reg;
    logic [craft_pkg::WORD_W-1:0]   ct_reg;
    logic                           parity_reg;
    logic                           parity_next;

    assign in_ready           = !valid_reg || cipher.ready;
    assign cipher.valid       = valid_reg;
    assign cipher.ciphertext  = ct_reg;
    assign cipher.mask_parity = parity_reg;

    // parity of masked plaintext xor masked ciphertext
    assign parity_next = ^((in_data.plain & input_mask) ^ (in_data.state & output_mask));

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            ct_reg     <= in_data.state;
            parity_reg <= parity_next;
        end
    end

endmodule

`default_nettype wire
